// ===== rtl/core/sm4_pkg.sv =====
// SM4 package: S-box, FK/CK constants, register indexes and the round transforms.
package sm4_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD3    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE = 3'd4;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type FK0 = 32'ha3b1bac6;
   localparam word_type FK1 = 32'h56aa3350;
   localparam word_type FK2 = 32'h677d9197;
   localparam word_type FK3 = 32'hb27022dc;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // byte-wise substitution
   function automatic word_type tau(input word_type v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   // L' for key expansion: rotations 13 and 23
   function automatic word_type lin_key(input word_type b);
      return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   // L for the data rounds: rotations 2, 10, 18 and 24
   function automatic word_type lin_data(input word_type b);
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

   // CK word: byte j is (4i+j)*7 mod 256
   function automatic word_type ck_word(input logic [7:0] idx);
      logic [7:0] base;
      word_type   w;
      base = {idx[5:0], 2'b00};
      w = '0;
      for (int j = 0; j < 4; j++) begin
         w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
      end
      return w;
   endfunction

endpackage

// ===== rtl/core/sm4_block_cipher.sv =====
// SM4 block cipher top level: key expansion, round key store and round sequencer.
//
// SM4 ECB cipher. Write the four key words and decrypt_mode through the csr_ port while
// busy is low; a key write marks the round keys stale. An item is taken when start is
// high and busy is low. With fresh round keys a block first reads the first round key
// from the store, then runs through the single shared round function (32 rounds), and
// the result is registered and appears on the rsp_ ports with rsp_strobe high for
// exactly one cycle. The first block after a key change first runs the key schedule,
// one round key per cycle into the store. busy falls in the cycle of the strobe, so the
// next block may be started there. The receiver cannot stall the result.
module sm4_block_cipher #(
   parameter int unsigned ROUNDS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [31:0]                      req_block_word0,
   input  logic [31:0]                      req_block_word1,
   input  logic [31:0]                      req_block_word2,
   input  logic [31:0]                      req_block_word3,
   output logic                             rsp_strobe,
   output logic [31:0]                      rsp_result_word0,
   output logic [31:0]                      rsp_result_word1,
   output logic [31:0]                      rsp_result_word2,
   output logic [31:0]                      rsp_result_word3,
   input  logic                             csr_write_en,
   input  logic [sm4_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_write_data
);

   localparam int unsigned RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam logic [RW-1:0] LAST_RND = RW'(ROUNDS - 1);

   typedef enum logic [1:0] {
      IDLE,
      EXPAND,
      LOAD,
      RUN
   } state_type;

   state_type             state_ff, state_in;
   logic [RW-1:0]         rnd_ff, rnd_in;
   logic                  keys_ready_ff, keys_ready_in;
   logic                  mode_ff;
   sm4_pkg::word_type     key_ff [4];
   sm4_pkg::word_type     x_ff [4];
   sm4_pkg::word_type     x_in [4];
   sm4_pkg::word_type     k_ff [4];
   sm4_pkg::word_type     k_in [4];
   logic                  strobe_ff, strobe_in;
   sm4_pkg::word_type     res_ff [4];
   logic                  res_load;

   // round key store
   sm4_pkg::word_type     rk_mem [ROUNDS];
   sm4_pkg::word_type     rk_rd_ff;
   logic                  mem_we;
   logic [RW-1:0]         rd_idx;
   logic [RW-1:0]         rd_addr;

   sm4_pkg::word_type     mix;
   sm4_pkg::word_type     sub;
   sm4_pkg::word_type     nk;
   sm4_pkg::word_type     nx;

   logic                  accept;

   assign accept = start && (state_ff == IDLE);
   assign busy   = (state_ff != IDLE);

   // shared S-box layer; key schedule and data rounds never run together
   always_comb begin
      if (state_ff == EXPAND) begin
         mix = k_ff[1] ^ k_ff[2] ^ k_ff[3] ^ sm4_pkg::ck_word(8'(rnd_ff));
      end else begin
         mix = x_ff[1] ^ x_ff[2] ^ x_ff[3] ^ rk_rd_ff;
      end
      sub = sm4_pkg::tau(mix);
      nk  = k_ff[0] ^ sm4_pkg::lin_key(sub);
      nx  = x_ff[0] ^ sm4_pkg::lin_data(sub);
   end

   // key for the round after this one; wraps harmlessly on the last round
   assign rd_idx  = (state_ff == LOAD) ? '0 : RW'(rnd_ff + 1'b1);
   assign rd_addr = mode_ff ? RW'(LAST_RND - rd_idx) : rd_idx;

   always_comb begin
      state_in      = state_ff;
      rnd_in        = rnd_ff;
      keys_ready_in = keys_ready_ff;
      strobe_in     = 1'b0;
      mem_we        = 1'b0;
      res_load      = 1'b0;
      x_in          = x_ff;
      k_in          = k_ff;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               x_in[0] = req_block_word0;
               x_in[1] = req_block_word1;
               x_in[2] = req_block_word2;
               x_in[3] = req_block_word3;
               k_in[0] = key_ff[0] ^ sm4_pkg::FK0;
               k_in[1] = key_ff[1] ^ sm4_pkg::FK1;
               k_in[2] = key_ff[2] ^ sm4_pkg::FK2;
               k_in[3] = key_ff[3] ^ sm4_pkg::FK3;
               rnd_in  = '0;
               state_in = keys_ready_ff ? LOAD : EXPAND;
            end
         end
         EXPAND: begin
            mem_we  = 1'b1;
            k_in[0] = k_ff[1];
            k_in[1] = k_ff[2];
            k_in[2] = k_ff[3];
            k_in[3] = nk;
            rnd_in  = RW'(rnd_ff + 1'b1);
            if (rnd_ff == LAST_RND) begin
               keys_ready_in = 1'b1;
               state_in      = LOAD;
            end
         end
         LOAD: begin
            rnd_in   = '0;
            state_in = RUN;
         end
         RUN: begin
            x_in[0] = x_ff[1];
            x_in[1] = x_ff[2];
            x_in[2] = x_ff[3];
            x_in[3] = nx;
            rnd_in  = RW'(rnd_ff + 1'b1);
            if (rnd_ff == LAST_RND) begin
               res_load  = 1'b1;
               strobe_in = 1'b1;
               state_in  = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      // any key word write makes the stored schedule stale
      if (csr_write_en && (csr_index == sm4_pkg::CSR_KEY_WORD0 ||
                           csr_index == sm4_pkg::CSR_KEY_WORD1 ||
                           csr_index == sm4_pkg::CSR_KEY_WORD2 ||
                           csr_index == sm4_pkg::CSR_KEY_WORD3)) begin
         keys_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rk_mem[rnd_ff] <= nk;
      end
      rk_rd_ff <= rk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         rnd_ff        <= '0;
         keys_ready_ff <= 1'b0;
         strobe_ff     <= 1'b0;
         mode_ff       <= 1'b0;
         key_ff        <= '{default: '0};
      end else begin
         state_ff      <= state_in;
         rnd_ff        <= rnd_in;
         keys_ready_ff <= keys_ready_in;
         strobe_ff     <= strobe_in;
         if (csr_write_en) begin
            unique case (csr_index)
               sm4_pkg::CSR_KEY_WORD0:    key_ff[0] <= csr_write_data;
               sm4_pkg::CSR_KEY_WORD1:    key_ff[1] <= csr_write_data;
               sm4_pkg::CSR_KEY_WORD2:    key_ff[2] <= csr_write_data;
               sm4_pkg::CSR_KEY_WORD3:    key_ff[3] <= csr_write_data;
               sm4_pkg::CSR_DECRYPT_MODE: mode_ff   <= csr_write_data[0];
               default: ;
            endcase
         end
      end
      x_ff <= x_in;
      k_ff <= k_in;
      // outputs in reverse order: X35, X34, X33, X32
      if (res_load) begin
         res_ff[0] <= nx;
         res_ff[1] <= x_ff[3];
         res_ff[2] <= x_ff[2];
         res_ff[3] <= x_ff[1];
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_result_word0 = res_ff[0];
   assign rsp_result_word1 = res_ff[1];
   assign rsp_result_word2 = res_ff[2];
   assign rsp_result_word3 = res_ff[3];

`ifndef NO_ASSERTIONS
   // a result only ever follows the last data round
   a_strobe_after_run: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(state_ff) == RUN && $past(rnd_ff) == LAST_RND))
      else $error("result strobe without a completed last round");

   // data rounds never start on a stale schedule
   a_load_keys_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == LOAD) |-> keys_ready_ff)
      else $error("round key read with stale schedule");

   // a block taken with stale keys goes through key expansion first
   a_stale_expand: assert property (@(posedge clock) disable iff (reset)
      (accept && !keys_ready_ff) |=> (state_ff == EXPAND))
      else $error("stale keys not expanded");

   // store is written only during key expansion
   a_we_expand: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == EXPAND && !keys_ready_ff))
      else $error("round key store written outside expansion");
`endif

endmodule
